// ===== src/bst_pkg.sv =====
// shared types and byte constants for the byte stream tokenizer
package bst_pkg;

    typedef enum logic [1:0] {
        KIND_NUM    = 2'd0,
        KIND_IDENT  = 2'd1,
        KIND_SINGLE = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] lexeme;
        logic       tok_start;
        logic       tok_end;
        logic       last;
    } t_token;

    localparam int QUEUE_DEPTH = 4;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_US    = 8'h5F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

// ===== src/bst_scan.sv =====
// scanner state and byte classification, up to two tokens per transfer
module bst_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_byte,
    input  logic            i_eos,
    output logic [1:0]      o_num,
    output bst_pkg::t_token o_tok0,
    output bst_pkg::t_token o_tok1
);
    import bst_pkg::*;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_NUM     = 4'b0010,
        MODE_IDENT   = 4'b0100,
        MODE_COMMENT = 4'b1000
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [7:0] r_held, n_held;
    logic       r_first, n_first;

    logic   is_dig, is_alpha, is_sp, is_brk;
    t_mode  idle_mode;
    logic   idle_hold, idle_emit;
    t_token idle_tok, held_tok;
    logic   cont;

    always_comb begin
        is_dig   = i_byte inside {[8'h30:8'h39]};
        is_alpha = i_byte inside {CH_US, [8'h61:8'h7A], [8'h41:8'h5A]};
        is_brk   = i_byte inside {CH_CR, CH_LF};
        is_sp    = i_byte inside {CH_CR, CH_LF, CH_SPACE, CH_TAB, CH_VT, CH_FF};

        idle_mode = MODE_IDLE;
        idle_hold = 1'b0;
        idle_emit = 1'b0;
        if (is_dig) begin
            idle_mode = MODE_NUM;
            idle_hold = 1'b1;
        end else if (is_alpha) begin
            idle_mode = MODE_IDENT;
            idle_hold = 1'b1;
        end else if (is_sp) begin
            idle_mode = MODE_IDLE;
        end else if (i_byte == CH_HASH) begin
            idle_mode = MODE_COMMENT;
        end else begin
            idle_emit = 1'b1;
        end
        idle_tok = '{kind: KIND_SINGLE, lexeme: i_byte, tok_start: 1'b1,
                     tok_end: 1'b1, last: 1'b0};

        held_tok = '{kind: (r_mode == MODE_NUM) ? KIND_NUM : KIND_IDENT,
                     lexeme: r_held, tok_start: r_first, tok_end: 1'b1, last: 1'b0};
        cont = (r_mode == MODE_NUM) ? is_dig : (is_dig || is_alpha);

        n_mode  = r_mode;
        n_held  = r_held;
        n_first = r_first;
        o_num   = 2'd0;
        o_tok0  = '0;
        o_tok1  = '0;

        if (i_eos) begin
            if ((r_mode == MODE_NUM) || (r_mode == MODE_IDENT)) begin
                o_tok0 = held_tok;
                o_tok1 = '{kind: KIND_END, lexeme: 8'h00, tok_start: 1'b1,
                           tok_end: 1'b1, last: 1'b1};
                o_num  = 2'd2;
            end else begin
                o_tok0 = '{kind: KIND_END, lexeme: 8'h00, tok_start: 1'b1,
                           tok_end: 1'b1, last: 1'b1};
                o_num  = 2'd1;
            end
            n_mode  = MODE_IDLE;
            n_held  = 8'h00;
            n_first = 1'b0;
        end else begin
            case (r_mode)
                MODE_IDLE: begin
                    n_mode = idle_mode;
                    if (idle_hold) begin
                        n_held  = i_byte;
                        n_first = 1'b1;
                    end
                    if (idle_emit) begin
                        o_tok0      = idle_tok;
                        o_tok0.last = 1'b1;
                        o_num       = 2'd1;
                    end
                end
                MODE_COMMENT: begin
                    if (is_brk) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_NUM, MODE_IDENT: begin
                    o_tok0 = held_tok;
                    if (cont) begin
                        o_tok0.tok_end = 1'b0;
                        o_tok0.last    = 1'b1;
                        o_num          = 2'd1;
                        n_held         = i_byte;
                        n_first        = 1'b0;
                    end else begin
                        n_mode  = idle_mode;
                        n_held  = idle_hold ? i_byte : 8'h00;
                        n_first = idle_hold;
                        if (idle_emit) begin
                            o_tok1      = idle_tok;
                            o_tok1.last = 1'b1;
                            o_num       = 2'd2;
                        end else begin
                            o_tok0.last = 1'b1;
                            o_num       = 2'd1;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_held  <= 8'h00;
            r_first <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_first <= n_first;
        end
    end

endmodule

// ===== src/byte_stream_tokenizer.sv =====
// byte stream tokenizer top level: input register, scanner and token queue
//
// input channel: i_in_valid / o_in_stall carry one source byte or an
// end-of-stream mark per transfer. output channel: o_out_valid / i_out_stall
// carry one lexeme byte per transfer with its kind, start, end and last flags.
// numbers, identifiers, single-character tokens and the end token come out in
// source order; identifier and number bytes are held back by one source byte
// so that the final byte can carry its end flag.
// a taken byte waits in the input register until the scanner advances; its tokens
// are written into the token queue and offered from its head in source order.
// throughput: one source byte per cycle while the token queue has room; a byte
// that closes a token and also gives a single-character token yields two output
// transfers. the four-entry token queue sets this: the scanner advances
// only while two entries are free after this cycle's output transfer.
// stall: while i_out_stall is high the queue holds and fills; once it cannot
// take two more tokens the input register holds and o_in_stall rises.
// reset: synchronous, active low; empties the queue and input register and
// returns the scanner to between tokens.
module byte_stream_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_byte_value,
    input  logic       i_end_of_stream,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_token_kind,
    output logic [7:0] o_lexeme_byte,
    output logic       o_token_start,
    output logic       o_token_end,
    output logic       o_item_last
);
    import bst_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eos;
    t_token           r_q [QUEUE_DEPTH];
    t_token           n_q [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic             pop, proc, in_fire;
    logic [CNT_W-1:0] cnt_ap;
    logic [1:0]       num;
    t_token           tok0, tok1;

    assign pop        = (r_cnt != '0) && !i_out_stall;
    assign cnt_ap     = r_cnt - CNT_W'(pop);
    assign proc       = r_in_valid && (cnt_ap <= CNT_W'(QUEUE_DEPTH - 2));
    assign o_in_stall = r_in_valid && !proc;
    assign in_fire    = i_in_valid && !o_in_stall;

    bst_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc),
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .o_num   (num),
        .o_tok0  (tok0),
        .o_tok1  (tok1)
    );

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && (i < QUEUE_DEPTH - 1)) begin
                n_q[i] = r_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end else begin
                n_q[i] = r_q[i];
            end
            if (proc && (num != 2'd0) && (CNT_W'(i) == cnt_ap)) begin
                n_q[i] = tok0;
            end
            if (proc && (num == 2'd2) && (CNT_W'(i) == cnt_ap + CNT_W'(1))) begin
                n_q[i] = tok1;
            end
        end
        n_cnt = proc ? cnt_ap + CNT_W'(num) : cnt_ap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_byte_value;
            r_in_eos  <= i_end_of_stream;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_out_valid   = (r_cnt != '0);
    assign o_token_kind  = r_q[0].kind;
    assign o_lexeme_byte = r_q[0].lexeme;
    assign o_token_start = r_q[0].tok_start;
    assign o_token_end   = r_q[0].tok_end;
    assign o_item_last   = r_q[0].last;

endmodule

// ===== sim/byte_stream_tokenizer_tb.sv =====
// self-checking testbench for byte_stream_tokenizer with random source text and backpressure
`timescale 1ns / 100ps

module byte_stream_tokenizer_tb;
    import bst_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_FROM      = 1500;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int SRC_ITEMS      = 1700;
    localparam int MAX_PRINTS     = 60;

    typedef enum logic [1:0] {
        SCAN_IDLE    = 2'd0,
        SCAN_NUM     = 2'd1,
        SCAN_IDENT   = 2'd2,
        SCAN_COMMENT = 2'd3
    } t_scan;

    typedef struct packed {
        logic [7:0] value;
        logic       eos;
    } t_src_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_byte_value = 8'd0;
    logic       i_end_of_stream = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_token_kind;
    logic [7:0] o_lexeme_byte;
    logic       o_token_start;
    logic       o_token_end;
    logic       o_item_last;

    logic       rand_stall = 1'b0;
    logic       hold_off = 1'b0;
    int         cyc = 0;
    int         idle_cnt = 0;
    int         err_cnt = 0;
    int         send_gap = 0;
    int         stall_left = 0;

    t_src_item  src_q[$];
    t_token     tok_exp_q[$];
    t_token     step_toks[$];

    t_scan      scan_mode = SCAN_IDLE;
    logic [7:0] held_byte = 8'd0;
    logic       held_first = 1'b0;

    assign i_out_stall = rand_stall | hold_off;

    byte_stream_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_byte_value    (i_byte_value),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_token_kind    (o_token_kind),
        .o_lexeme_byte   (o_lexeme_byte),
        .o_token_start   (o_token_start),
        .o_token_end     (o_token_end),
        .o_item_last     (o_item_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        if (err_cnt < MAX_PRINTS) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        err_cnt++;
    endtask

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alpha_us(logic [7:0] b);
        return b == CH_US || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_space(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF
            || b == CH_LF || b == CH_CR;
    endfunction

    function automatic void emit_token(t_kind k, logic [7:0] b, logic s, logic e);
        t_token tk;
        tk.kind      = k;
        tk.lexeme    = b;
        tk.tok_start = s;
        tk.tok_end   = e;
        tk.last      = 1'b0;
        step_toks.push_back(tk);
    endfunction

    function automatic void scan_between_tokens(logic [7:0] b);
        if (is_digit(b)) begin
            scan_mode  = SCAN_NUM;
            held_byte  = b;
            held_first = 1'b1;
        end else if (is_alpha_us(b)) begin
            scan_mode  = SCAN_IDENT;
            held_byte  = b;
            held_first = 1'b1;
        end else if (is_space(b)) begin
        end else if (b == CH_HASH) begin
            scan_mode = SCAN_COMMENT;
        end else begin
            emit_token(KIND_SINGLE, b, 1'b1, 1'b1);
        end
    endfunction

    function automatic void predict_tokens(t_src_item it);
        t_kind run_kind;
        bit    cont;
        step_toks.delete();
        run_kind = (scan_mode == SCAN_NUM) ? KIND_NUM : KIND_IDENT;
        if (it.eos) begin
            if (scan_mode == SCAN_NUM || scan_mode == SCAN_IDENT) begin
                emit_token(run_kind, held_byte, held_first, 1'b1);
            end
            emit_token(KIND_END, 8'd0, 1'b1, 1'b1);
            scan_mode  = SCAN_IDLE;
            held_byte  = 8'd0;
            held_first = 1'b0;
        end else if (scan_mode == SCAN_IDLE) begin
            scan_between_tokens(it.value);
        end else if (scan_mode == SCAN_COMMENT) begin
            if (it.value == CH_CR || it.value == CH_LF) begin
                scan_mode = SCAN_IDLE;
            end
        end else begin
            cont = (scan_mode == SCAN_NUM) ? is_digit(it.value)
                                           : (is_digit(it.value) || is_alpha_us(it.value));
            if (cont) begin
                emit_token(run_kind, held_byte, held_first, 1'b0);
                held_byte  = it.value;
                held_first = 1'b0;
            end else begin
                emit_token(run_kind, held_byte, held_first, 1'b1);
                scan_mode  = SCAN_IDLE;
                held_byte  = 8'd0;
                held_first = 1'b0;
                scan_between_tokens(it.value);
            end
        end
        if (step_toks.size() > 0) begin
            step_toks[step_toks.size() - 1].last = 1'b1;
        end
        foreach (step_toks[i]) begin
            tok_exp_q.push_back(step_toks[i]);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (((cyc / 300) % 4) == 2) begin
            return 0;
        end
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 40);
        end
    endfunction

    function automatic void add_src(logic [7:0] b, logic eos);
        t_src_item it;
        it.value = b;
        it.eos   = eos;
        src_q.push_back(it);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_alpha_us();
        int r;
        r = $urandom_range(0, 52);
        if (r == 52) begin
            return CH_US;
        end else if (r < 26) begin
            return 8'("a" + r);
        end else begin
            return 8'("A" + r - 26);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_src_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                it.value = i_byte_value;
                it.eos   = i_end_of_stream;
                predict_tokens(it);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (src_q.size() > 0) begin
                    it = src_q.pop_front();
                    i_byte_value    <= it.value;
                    i_end_of_stream <= it.eos;
                    i_in_valid      <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and random receiver stall
    always @(posedge i_clk) begin
        t_token tk;
        if (!i_rst_n) begin
            rand_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (tok_exp_q.size() == 0) begin
                    report($sformatf("unexpected token kind %0d byte %02h",
                                     o_token_kind, o_lexeme_byte));
                end else begin
                    tk = tok_exp_q.pop_front();
                    if (o_token_kind !== tk.kind || o_lexeme_byte !== tk.lexeme
                        || o_token_start !== tk.tok_start || o_token_end !== tk.tok_end
                        || o_item_last !== tk.last) begin
                        report($sformatf({"got kind %0d byte %02h start %b end %b last %b,",
                                          " want kind %0d byte %02h start %b end %b last %b"},
                                         o_token_kind, o_lexeme_byte, o_token_start,
                                         o_token_end, o_item_last, tk.kind, tk.lexeme,
                                         tk.tok_start, tk.tok_end, tk.last));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rand_stall <= 1'b1;
            end else begin
                stall_left = ($urandom_range(0, 1) == 1) ? pick_gap() : 0;
                rand_stall <= (stall_left > 0);
            end
        end
    end

    // long receiver hold-off and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cyc      <= 0;
            idle_cnt <= 0;
            hold_off <= 1'b0;
        end else begin
            cyc      <= cyc + 1;
            hold_off <= (cyc >= HOLD_FROM && cyc < HOLD_FROM + HOLD_CYCLES);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cnt <= 0;
            end else begin
                idle_cnt <= idle_cnt + 1;
            end
            if (idle_cnt >= WATCHDOG_LIMIT) begin
                $display("FAIL byte_stream_tokenizer");
                $finish;
            end
        end
    end

    initial begin
        string s;
        int    r;
        int    n;
        s = "12a_Z9 #c";
        for (int i = 0; i < s.len(); i++) begin
            add_src(s[i], 1'b0);
        end
        add_src(CH_CR, 1'b0);
        add_src("0", 1'b0);
        add_src(8'h00, 1'b0);
        add_src(8'hFF, 1'b0);
        add_src(8'h80, 1'b0);
        add_src("4", 1'b0);
        add_src("+", 1'b0);
        add_src(8'hFF, 1'b1);
        add_src("x", 1'b0);
        add_src(8'h00, 1'b1);
        add_src(CH_HASH, 1'b0);
        add_src("q", 1'b0);
        add_src(8'h55, 1'b1);
        add_src(CH_LF, 1'b1);

        while (src_q.size() < SRC_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                n = $urandom_range(1, 6);
                repeat (n) add_src(pick_digit(), 1'b0);
            end else if (r < 50) begin
                add_src(pick_alpha_us(), 1'b0);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    add_src(($urandom_range(0, 3) == 0) ? pick_digit() : pick_alpha_us(),
                            1'b0);
                end
            end else if (r < 65) begin
                case ($urandom_range(0, 5))
                    0: add_src(CH_SPACE, 1'b0);
                    1: add_src(CH_TAB, 1'b0);
                    2: add_src(CH_VT, 1'b0);
                    3: add_src(CH_FF, 1'b0);
                    4: add_src(CH_LF, 1'b0);
                    default: add_src(CH_CR, 1'b0);
                endcase
            end else if (r < 73) begin
                add_src(CH_HASH, 1'b0);
                n = $urandom_range(0, 5);
                repeat (n) add_src(8'($urandom_range(0, 255)), 1'b0);
                add_src(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF, 1'b0);
            end else if (r < 88) begin
                case ($urandom_range(0, 3))
                    0: add_src(8'($urandom_range(128, 255)), 1'b0);
                    1: add_src(8'h00, 1'b0);
                    default: add_src(8'($urandom_range(33, 47)), 1'b0);
                endcase
            end else if (r < 93) begin
                add_src(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                add_src(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        add_src(8'd0, 1'b1);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (src_q.size() > 0 || i_in_valid || tok_exp_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tok_exp_q.size() != 0) begin
            report($sformatf("%0d tokens never arrived", tok_exp_q.size()));
        end
        if (err_cnt == 0) begin
            $display("PASS byte_stream_tokenizer");
        end else begin
            $display("FAIL byte_stream_tokenizer");
        end
        $finish;
    end

endmodule
